// ===== hdl/permutation_unrank_macros.svh =====
// Assertion macros for the permutation unranking block.
// Used by the checker module; depends on nothing else.
`ifndef PERMUTATION_UNRANK_MACROS_SVH
`define PERMUTATION_UNRANK_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PU_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define PU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/perm_pkg.sv =====
// Shared types, constants and the factorial table of the permutation unranking block.
// Used by perm_ctrl, perm_sweep, permutation_unrank and perm_chk; depends on nothing.
`default_nettype none

package perm_pkg;

	localparam int SIZE_W     = 4;
	localparam int RANK_W     = 29;
	localparam int ELEM_W     = 4;
	localparam int FACT_W     = RANK_W + 1;
	localparam int FACT_LEN   = 21;
	localparam int FACT_IDX_W = 5;

	localparam logic [FACT_W-1:0] FACT_SAT = FACT_W'(1) << RANK_W;

	localparam logic [63:0] FACT_TABLE [FACT_LEN] = '{
		64'd1, 64'd1, 64'd2, 64'd6, 64'd24, 64'd120, 64'd720, 64'd5040, 64'd40320,
		64'd362880, 64'd3628800, 64'd39916800, 64'd479001600, 64'd6227020800,
		64'd87178291200, 64'd1307674368000, 64'd20922789888000,
		64'd355687428096000, 64'd6402373705728000, 64'd121645100408832000,
		64'd2432902008176640000
	};

	typedef enum logic {
		ST_IDLE,
		ST_SWEEP
	} perm_state_t;

	typedef struct packed {
		logic                  load;
		logic                  step;
		logic                  wrap;
		logic                  last;
		logic [FACT_IDX_W-1:0] fact_idx;
	} sweep_ctl_t;

	// Factorial clipped to 2^RANK_W, which already exceeds every rank.
	function automatic logic [FACT_W-1:0] fact_sat(input logic [FACT_IDX_W-1:0] idx);
		logic [63:0] f;
		if (int'(idx) < FACT_LEN) begin
			f = FACT_TABLE[idx];
		end else begin
			f = '1;
		end
		if (f > 64'(FACT_SAT)) begin
			return FACT_SAT;
		end
		return FACT_W'(f);
	endfunction

endpackage

`default_nettype wire

// ===== hdl/perm_ctrl.sv =====
// Sequencer of the permutation unranking block: state, position count, bit pointer.
// Depends on perm_pkg.
`default_nettype none

module perm_ctrl
	import perm_pkg::*;
#(
	parameter int MAX_N = 12,
	localparam int PtrW = (MAX_N > 1) ? $clog2(MAX_N) : 1,
	localparam int CntW = $clog2(MAX_N + 1)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              go,
	input  wire logic [SIZE_W-1:0] set_size,
	output logic                   busy,
	output sweep_ctl_t             ctl,
	output logic [PtrW-1:0]        ptr
);

	perm_state_t     state_q, state_d;
	logic [CntW-1:0] left_q;
	logic [PtrW-1:0] ptr_q;
	logic            sweep, wrap;

	assign sweep = (state_q == ST_SWEEP);
	assign wrap  = sweep && (ptr_q == PtrW'(MAX_N - 1));
	assign ptr   = ptr_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (go) state_d = ST_SWEEP;
			end
			ST_SWEEP: begin
				if (wrap && (left_q == CntW'(1))) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		busy         = sweep;
		ctl.load     = (state_q == ST_IDLE) && go;
		ctl.step     = sweep;
		ctl.wrap     = wrap;
		ctl.last     = wrap && (left_q == CntW'(1));
		ctl.fact_idx = FACT_IDX_W'(left_q - CntW'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			left_q  <= '0;
			ptr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (ctl.load) begin
				left_q <= CntW'(set_size);
				ptr_q  <= '0;
			end else if (sweep) begin
				ptr_q <= wrap ? '0 : ptr_q + PtrW'(1);
				if (wrap) left_q <= left_q - CntW'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ===== hdl/perm_sweep.sv =====
// Bit-serial datapath: rotating unused-value mask and remaining rank; one value per mask sweep.
// Depends on perm_pkg; driven by perm_ctrl.
`default_nettype none

module perm_sweep
	import perm_pkg::*;
#(
	parameter int MAX_N = 12,
	localparam int PtrW = (MAX_N > 1) ? $clog2(MAX_N) : 1
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire sweep_ctl_t        ctl,
	input  wire logic [PtrW-1:0]   ptr,
	input  wire logic [RANK_W-1:0] rank,
	output logic [ELEM_W-1:0]      pick_elem
);

	logic [MAX_N-1:0]  mask_q, mask_d;
	logic [RANK_W-1:0] rem_q;
	logic              found_q;
	logic [ELEM_W-1:0] elem_q;
	logic [FACT_W-1:0] fact;
	logic              cand, ge, take, pick;

	assign fact = fact_sat(ctl.fact_idx);
	assign ge   = {1'b0, rem_q} >= fact;
	assign cand = !found_q && mask_q[0];
	assign take = cand && ge;
	assign pick = cand && !ge;

	assign mask_d    = MAX_N'({mask_q[0] & ~pick, mask_q} >> 1);
	assign pick_elem = found_q ? elem_q : ELEM_W'(ptr) + ELEM_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q  <= '1;
			rem_q   <= '0;
			found_q <= 1'b0;
			elem_q  <= '0;
		end else if (ctl.load) begin
			mask_q  <= '1;
			rem_q   <= rank - RANK_W'(1);
			found_q <= 1'b0;
		end else if (ctl.step) begin
			mask_q  <= mask_d;
			if (take) rem_q <= rem_q - fact[RANK_W-1:0];
			found_q <= ctl.wrap ? 1'b0 : (found_q | pick);
			if (pick) elem_q <= pick_elem;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/permutation_unrank.sv =====
// Permutation unranking, top level: set size n and one-based rank in, elements out.
// Timing: an error transaction shows its result in the cycle after acceptance;
// otherwise each element is registered as the mask sweep for its position wraps.
// Throughput: no new transaction is taken until the last mask sweep ends; the sweep
// checks one mask bit per cycle. An error transaction can be taken every cycle while idle. The receiver cannot stall.
// Reset: arst_n clears the sequencer and the result strobe; the block is idle at once.
`default_nettype none

module permutation_unrank
	import perm_pkg::*;
#(
	parameter int MAX_N = 12,
	localparam int PtrW = (MAX_N > 1) ? $clog2(MAX_N) : 1
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [SIZE_W-1:0] set_size,
	input  wire logic [RANK_W-1:0] rank,
	output logic                   busy,
	output logic                   valid,
	output logic [ELEM_W-1:0]      element,
	output logic                   last,
	output logic                   error
);

	localparam logic [FACT_IDX_W-1:0] MaxNv = FACT_IDX_W'(MAX_N);

	sweep_ctl_t        ctl;
	logic [PtrW-1:0]   ptr;
	logic [ELEM_W-1:0] pick_elem;
	logic              err, accept, go;
	logic              valid_q, last_q, error_q;
	logic [ELEM_W-1:0] element_q;

	assign err = (set_size == '0) || (FACT_IDX_W'(set_size) > MaxNv) || (rank == '0) ||
		({1'b0, rank} > fact_sat(FACT_IDX_W'(set_size)));
	assign accept = start && !busy;
	assign go     = start && !err;

	perm_ctrl #(.MAX_N(MAX_N)) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (go),
		.set_size (set_size),
		.busy     (busy),
		.ctl      (ctl),
		.ptr      (ptr)
	);

	perm_sweep #(.MAX_N(MAX_N)) u_sweep (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.ptr       (ptr),
		.rank      (rank),
		.pick_elem (pick_elem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= (accept && err) || ctl.wrap;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && err) begin
			element_q <= '0;
			last_q    <= 1'b1;
			error_q   <= 1'b1;
		end else if (ctl.wrap) begin
			element_q <= pick_elem;
			last_q    <= ctl.last;
			error_q   <= 1'b0;
		end
	end

	assign valid   = valid_q;
	assign element = element_q;
	assign last    = last_q;
	assign error   = error_q;

endmodule

`default_nettype wire

// ===== hdl/perm_chk.sv =====
// Port-level checker for permutation_unrank, attached by bind.
// Depends on perm_pkg and permutation_unrank_macros.svh.
`default_nettype none
`include "permutation_unrank_macros.svh"

module perm_chk
	import perm_pkg::*;
#(
	parameter int MAX_N = 12
) (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              start,
	input wire logic [SIZE_W-1:0] set_size,
	input wire logic [RANK_W-1:0] rank,
	input wire logic              busy,
	input wire logic              valid,
	input wire logic [ELEM_W-1:0] element,
	input wire logic              last,
	input wire logic              error
);

	`PU_ASSERT_NOW(a_err_shape, clk, arst_n, valid && error, (element == '0) && last, "error result not shaped")
	`PU_ASSERT_NEXT(a_zero_rank, clk, arst_n, start && !busy && (rank == '0), valid && error && !busy, "rank zero not rejected")
	`PU_ASSERT_NEXT(a_single, clk, arst_n, start && !busy && (set_size == SIZE_W'(1)) && (rank == RANK_W'(1)), busy && !valid, "transaction not started")
	`PU_ASSERT_NOW(a_busy_last, clk, arst_n, valid && !error, busy == !last, "busy out of step with last")
	`PU_ASSERT_NOW(a_elem_nz, clk, arst_n, valid && !error && (MAX_N < 16), element != '0, "zero element on good result")

endmodule

bind permutation_unrank perm_chk #(.MAX_N(MAX_N)) u_perm_chk (.*);

`default_nettype wire
